### sv/gb5_pkg.sv
// Shared types and constants of the 5x5 Gaussian blur block.
package gb5_pkg;

    // Pixel format: three 8-bit channels.
    localparam int CHAN_W   = 8;
    localparam int NUM_CHAN = 3;
    localparam int PIX_W    = CHAN_W * NUM_CHAN;

    // Window size and kernel taps; the 2D kernel is the outer product of TAP with itself.
    localparam int WIN   = 5;
    localparam int TAP_W = 3;
    localparam logic [TAP_W-1:0] TAP [WIN] = '{3'd1, 3'd2, 3'd4, 3'd2, 3'd1};

    // The first column and row whose window lies fully inside the frame, counted at the input side.
    localparam int INNER_START = 4;

    // Arithmetic widths: a weighted row sum is at most 10*255, the full sum at most 100*255.
    localparam int ROW_SUM_W = 12;
    localparam int TOTAL_W   = 15;

    // Division by 100 as a multiply by ceil(2^21/100); exact for every sum below 43690.
    localparam int                 RECIP_SHIFT = 21;
    localparam logic [TOTAL_W-1:0] RECIP       = 15'd20972;
    localparam int                 PROD_W      = 2 * TOTAL_W;

    // Pipeline depth of a lane, from the window update to the registered quotient.
    localparam int LANE_LAT = 3;

    // Output queue.
    localparam int QDEPTH  = 8;
    localparam int Q_AW    = $clog2(QDEPTH);
    localparam int Q_CNT_W = $clog2(QDEPTH + 1);

    // Cycles during which input is held off after a configuration write.
    localparam logic [1:0] HOLD_CYCLES = 2'd3;

    // Configuration registers.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_DATA_W-1:0] RESET_WIDTH  = 11'd640;
    localparam logic [CFG_DATA_W-1:0] RESET_HEIGHT = 11'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pixel_t;

    // What the merge stage needs to know about one result.
    typedef struct packed {
        logic   valid;
        logic   interior;
        logic   last;
        pixel_t pass;
    } merge_info_t;

    // One entry of the output queue.
    typedef struct packed {
        chan_t chan0;
        chan_t chan1;
        chan_t chan2;
        logic  frame_end;
    } out_item_t;

endpackage

### sv/gb5_pix_in_if.sv
// Input pixel channel with valid/ready handshake.
interface gb5_pix_in_if;
    logic          valid;
    logic          ready;
    gb5_pkg::chan_t chan0_in;
    gb5_pkg::chan_t chan1_in;
    gb5_pkg::chan_t chan2_in;
    logic          drain;

    modport source (output valid, output chan0_in, output chan1_in, output chan2_in,
                    output drain, input ready);
    modport sink (input valid, input chan0_in, input chan1_in, input chan2_in,
                  input drain, output ready);
endinterface

### sv/gb5_pix_out_if.sv
// Output pixel channel with valid/ready handshake.
interface gb5_pix_out_if;
    logic          valid;
    logic          ready;
    gb5_pkg::chan_t chan0_out;
    gb5_pkg::chan_t chan1_out;
    gb5_pkg::chan_t chan2_out;
    logic          frame_end;

    modport source (output valid, output chan0_out, output chan1_out, output chan2_out,
                    output frame_end, input ready);
    modport sink (input valid, input chan0_out, input chan1_out, input chan2_out,
                  input frame_end, output ready);
endinterface

### sv/gb5_cfg_if.sv
// Configuration write channel: register index and write data.
interface gb5_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [gb5_pkg::CFG_IDX_W-1:0]    index;
    logic [gb5_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### sv/gb5_line_store.sv
// Line history memory: one write port and a configurable number of registered read ports.
module gb5_line_store #(
    parameter int AW  = 12,
    parameter int DW  = 24,
    parameter int NRD = 2
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr [NRD],
    output logic [DW-1:0] rd_data [NRD]
);

    logic [DW-1:0] mem [2**AW];

    // Write and registered reads; a read of the address being written returns the old word.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        for (int i = 0; i < NRD; i++)
        begin
            rd_data[i] <= mem[rd_addr[i]];
        end
    end

endmodule

### sv/gb5_lane.sv
// One channel lane: 5x5 window, weighted sum and division by 100.
module gb5_lane (
    input  logic           clk,
    input  logic           shift_en,
    input  gb5_pkg::chan_t col_in [gb5_pkg::WIN],
    output gb5_pkg::chan_t quot
);

    gb5_pkg::chan_t                     window_reg   [gb5_pkg::WIN][gb5_pkg::WIN];
    logic [gb5_pkg::ROW_SUM_W-1:0]      row_sum_reg  [gb5_pkg::WIN];
    logic [gb5_pkg::ROW_SUM_W-1:0]      row_sum_next [gb5_pkg::WIN];
    logic [gb5_pkg::TOTAL_W-1:0]        total_reg;
    logic [gb5_pkg::TOTAL_W-1:0]        total_next;
    logic [gb5_pkg::PROD_W-1:0]         product;
    gb5_pkg::chan_t                     quot_reg;

    // Window shifts left by one column for every processed item; the new column enters on the right.
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            for (int k = 0; k < gb5_pkg::WIN; k++)
            begin
                for (int j = 0; j < gb5_pkg::WIN - 1; j++)
                begin
                    window_reg[k][j] <= window_reg[k][j+1];
                end
                window_reg[k][gb5_pkg::WIN-1] <= col_in[k];
            end
        end
    end

    // Horizontal pass: weighted sum along each window row.
    always_comb
    begin
        for (int k = 0; k < gb5_pkg::WIN; k++)
        begin
            row_sum_next[k] = '0;
            for (int j = 0; j < gb5_pkg::WIN; j++)
            begin
                row_sum_next[k] = row_sum_next[k]
                    + gb5_pkg::ROW_SUM_W'(window_reg[k][j])
                    * gb5_pkg::ROW_SUM_W'(gb5_pkg::TAP[j]);
            end
        end
    end

    // Vertical pass: weighted sum of the row sums.
    always_comb
    begin
        total_next = '0;
        for (int k = 0; k < gb5_pkg::WIN; k++)
        begin
            total_next = total_next
                + gb5_pkg::TOTAL_W'(row_sum_reg[k]) * gb5_pkg::TOTAL_W'(gb5_pkg::TAP[k]);
        end
    end

    // Truncating divide by 100 through the reciprocal.
    assign product = gb5_pkg::PROD_W'(total_reg) * gb5_pkg::PROD_W'(gb5_pkg::RECIP);

    always_ff @(posedge clk)
    begin
        row_sum_reg <= row_sum_next;
        total_reg   <= total_next;
        quot_reg    <= product[gb5_pkg::RECIP_SHIFT +: gb5_pkg::CHAN_W];
    end

    assign quot = quot_reg;

endmodule

### sv/gb5_merge.sv
// Merge stage: picks blurred or passed-through channels and queues results for the output.
module gb5_merge (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gb5_pkg::merge_info_t info,
    input  gb5_pkg::pixel_t      quot,
    gb5_pix_out_if.source        pix_out
);

    gb5_pkg::out_item_t              item;
    gb5_pkg::out_item_t              queue_reg [gb5_pkg::QDEPTH];
    logic [gb5_pkg::Q_AW-1:0]        wr_ptr_reg;
    logic [gb5_pkg::Q_AW-1:0]        wr_ptr_next;
    logic [gb5_pkg::Q_AW-1:0]        rd_ptr_reg;
    logic [gb5_pkg::Q_AW-1:0]        rd_ptr_next;
    logic [gb5_pkg::Q_CNT_W-1:0]     count_reg;
    logic [gb5_pkg::Q_CNT_W-1:0]     count_next;
    logic                            push;
    logic                            pop;

    // Interior pixels take the lane quotients; border pixels pass through.
    always_comb
    begin
        item.chan0     = info.interior ? quot[0] : info.pass[0];
        item.chan1     = info.interior ? quot[1] : info.pass[1];
        item.chan2     = info.interior ? quot[2] : info.pass[2];
        item.frame_end = info.last;
    end

    assign push = info.valid;
    assign pop  = pix_out.valid && pix_out.ready;

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= item;
        end
    end

    // Queue pointers and fill count.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + gb5_pkg::Q_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + gb5_pkg::Q_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + gb5_pkg::Q_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - gb5_pkg::Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Head of the queue drives the output channel.
    assign pix_out.valid     = (count_reg != '0);
    assign pix_out.chan0_out = queue_reg[rd_ptr_reg].chan0;
    assign pix_out.chan1_out = queue_reg[rd_ptr_reg].chan1;
    assign pix_out.chan2_out = queue_reg[rd_ptr_reg].chan2;
    assign pix_out.frame_end = queue_reg[rd_ptr_reg].frame_end;

    // The reservation in front of the pipeline must keep the queue from overflowing.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> count_reg < gb5_pkg::Q_CNT_W'(gb5_pkg::QDEPTH))
        else $error("output queue overflow");

endmodule

### sv/gaussian_blur_5x5_2d.sv
// Top level of the 5x5 Gaussian blur over a raster stream of 3-channel pixels.
// Throughput: one item per clock unless held off after a configuration write or while the
// output queue is fully reserved. The result for frame position p comes with the item at
// position p+2W+2 and passes stage 1, the window, 3 lane stages and the queue to pix_out.
// Reset clears the position counters and the output queue and loads 640x480; the line
// store is not cleared and needs no clearing pass.
module gaussian_blur_5x5_2d #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    gb5_cfg_if.sink       cfg,
    gb5_pix_in_if.sink    pix_in,
    gb5_pix_out_if.source pix_out
);

    localparam int LS_AW = $clog2(4 * MAX_WIDTH);
    localparam int W_W   = $clog2(MAX_WIDTH + 1);
    localparam int H_W   = $clog2(MAX_HEIGHT + 1);
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = H_W + 1;
    localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 2 * MAX_WIDTH + 3);
    localparam int LAG_W = W_W + 2;
    localparam int NROW  = gb5_pkg::WIN - 1;

    // Configuration registers and derived frame geometry.
    logic [gb5_pkg::CFG_DATA_W-1:0] width_cfg_reg;
    logic [gb5_pkg::CFG_DATA_W-1:0] height_cfg_reg;
    logic [1:0]                     hold_reg;
    logic [W_W-1:0]                 w_clamp;
    logic [H_W-1:0]                 h_clamp;
    logic [W_W-1:0]                 w_reg;
    logic [H_W-1:0]                 h_reg;
    logic [W_W+H_W-1:0]             area;
    logic [CNT_W-1:0]               n_reg;
    logic [LAG_W-1:0]               lag_reg;
    logic [LAG_W-1:0]               lag_m1_reg;
    logic                           big_reg;
    logic [LS_AW-1:0]               d_row_reg [NROW];
    logic [CNT_W-1:0]               nl_reg;
    logic [CNT_W-1:0]               nl_m1_reg;
    logic                           cfg_write;

    // Input position counters.
    logic [COL_W-1:0]               col_reg;
    logic [COL_W-1:0]               col_next;
    logic [ROW_W-1:0]               row_reg;
    logic [ROW_W-1:0]               row_next;
    logic [CNT_W-1:0]               cnt_reg;
    logic [CNT_W-1:0]               cnt_next;
    logic [COL_W-1:0]               col_base;
    logic [ROW_W-1:0]               row_base;
    logic [CNT_W-1:0]               cnt_base;
    logic [LS_AW-1:0]               wr_ptr_reg;
    logic [gb5_pkg::Q_CNT_W-1:0]    rsv_reg;
    logic [gb5_pkg::Q_CNT_W-1:0]    rsv_next;

    // Item decode.
    logic                           in_ready;
    logic                           accept;
    logic                           restart;
    logic                           in_frame;
    logic                           drop;
    logic                           process;
    logic                           emit;
    logic                           interior;
    logic                           last;
    logic                           out_take;
    gb5_pkg::pixel_t                px;

    // Pipeline.
    logic                           s1_valid_reg;
    logic                           s1_emit_reg;
    logic                           s1_interior_reg;
    logic                           s1_last_reg;
    gb5_pkg::pixel_t                s1_px_reg;
    gb5_pkg::merge_info_t           s2_info_reg;
    gb5_pkg::merge_info_t           info_pipe_reg [gb5_pkg::LANE_LAT];

    // Line store ports.
    logic [LS_AW-1:0]               rd_a_addr [2];
    logic [LS_AW-1:0]               rd_b_addr [2];
    logic [LS_AW-1:0]               rd_c_addr [1];
    logic [gb5_pkg::PIX_W-1:0]      rd_a_data [2];
    logic [gb5_pkg::PIX_W-1:0]      rd_b_data [2];
    logic [gb5_pkg::PIX_W-1:0]      rd_c_data [1];
    gb5_pkg::pixel_t                col_pix   [gb5_pkg::WIN];
    gb5_pkg::chan_t                 lane_col  [gb5_pkg::NUM_CHAN][gb5_pkg::WIN];
    gb5_pkg::pixel_t                lane_quot;

    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= gb5_pkg::RESET_WIDTH;
            height_cfg_reg <= gb5_pkg::RESET_HEIGHT;
        end
        else if (cfg_write)
        begin
            case (gb5_pkg::cfg_reg_t'(cfg.index))
                gb5_pkg::REG_IMAGE_WIDTH:  width_cfg_reg  <= cfg.data;
                gb5_pkg::REG_IMAGE_HEIGHT: height_cfg_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // Input is held off while the derived geometry settles after reset or a write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= gb5_pkg::HOLD_CYCLES;
        end
        else if (cfg_write)
        begin
            hold_reg <= gb5_pkg::HOLD_CYCLES;
        end
        else if (hold_reg != '0)
        begin
            hold_reg <= hold_reg - 2'd1;
        end
    end

    // Clamp the frame size to 1..MAX.
    always_comb
    begin
        if (width_cfg_reg == '0)
        begin
            w_clamp = W_W'(1);
        end
        else if (32'(width_cfg_reg) > MAX_WIDTH)
        begin
            w_clamp = W_W'(MAX_WIDTH);
        end
        else
        begin
            w_clamp = W_W'(width_cfg_reg);
        end

        if (height_cfg_reg == '0)
        begin
            h_clamp = H_W'(1);
        end
        else if (32'(height_cfg_reg) > MAX_HEIGHT)
        begin
            h_clamp = H_W'(MAX_HEIGHT);
        end
        else
        begin
            h_clamp = H_W'(height_cfg_reg);
        end
    end

    assign area = (W_W+H_W)'(w_reg) * (W_W+H_W)'(h_reg);

    // Derived geometry over three register stages: size, products and offsets, end counts.
    always_ff @(posedge clk)
    begin
        w_reg      <= w_clamp;
        h_reg      <= h_clamp;
        n_reg      <= CNT_W'(area);
        lag_reg    <= (LAG_W'(w_reg) << 1) + LAG_W'(2);
        lag_m1_reg <= (LAG_W'(w_reg) << 1) + LAG_W'(1);
        big_reg    <= (w_reg >= W_W'(gb5_pkg::WIN)) && (h_reg >= H_W'(gb5_pkg::WIN));
        for (int k = 0; k < NROW; k++)
        begin
            d_row_reg[k] <= LS_AW'(32'(w_reg) * (NROW - k));
        end
        nl_reg     <= n_reg + CNT_W'(lag_reg);
        nl_m1_reg  <= n_reg + CNT_W'(lag_m1_reg);
    end

    // Item decode: frame restart, drain handling, result and border decisions.
    assign in_ready = (hold_reg == '0) && (rsv_reg < gb5_pkg::Q_CNT_W'(gb5_pkg::QDEPTH));
    assign pix_in.ready = in_ready;
    assign accept   = pix_in.valid && in_ready;
    assign restart  = (cnt_reg >= nl_reg);
    assign in_frame = restart || (cnt_reg < n_reg);
    assign drop     = in_frame && pix_in.drain;
    assign process  = accept && !drop;
    assign emit     = !restart && (cnt_reg >= CNT_W'(lag_reg));
    assign last     = !restart && (cnt_reg == nl_m1_reg);
    assign interior = !restart && big_reg
                      && (col_reg >= COL_W'(gb5_pkg::INNER_START)) && (W_W'(col_reg) < w_reg)
                      && (row_reg >= ROW_W'(gb5_pkg::INNER_START)) && (row_reg < ROW_W'(h_reg));
    assign out_take = pix_out.valid && pix_out.ready;

    always_comb
    begin
        if (in_frame)
        begin
            px[0] = pix_in.chan0_in;
            px[1] = pix_in.chan1_in;
            px[2] = pix_in.chan2_in;
        end
        else
        begin
            px = '0;
        end
    end

    // Position counters; the row count saturates above any height.
    always_comb
    begin
        col_base = restart ? '0 : col_reg;
        row_base = restart ? '0 : row_reg;
        cnt_base = restart ? '0 : cnt_reg;
        col_next = col_reg;
        row_next = row_reg;
        cnt_next = cnt_reg;
        if (accept)
        begin
            col_next = col_base;
            row_next = row_base;
            cnt_next = cnt_base;
            if (!drop)
            begin
                if (last)
                begin
                    col_next = '0;
                    row_next = '0;
                    cnt_next = '0;
                end
                else
                begin
                    if (W_W'(col_base) + W_W'(1) >= w_reg)
                    begin
                        col_next = '0;
                        row_next = (row_base == '1) ? row_base : row_base + ROW_W'(1);
                    end
                    else
                    begin
                        col_next = col_base + COL_W'(1);
                    end
                    cnt_next = cnt_base + CNT_W'(1);
                end
            end
        end
    end

    // Output queue reservation: one slot per result in flight or queued.
    always_comb
    begin
        rsv_next = rsv_reg;
        if ((process && emit) && !out_take)
        begin
            rsv_next = rsv_reg + gb5_pkg::Q_CNT_W'(1);
        end
        else if (out_take && !(process && emit))
        begin
            rsv_next = rsv_reg - gb5_pkg::Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            cnt_reg    <= '0;
            wr_ptr_reg <= '0;
            rsv_reg    <= '0;
        end
        else
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            cnt_reg    <= cnt_next;
            rsv_reg    <= rsv_next;
            if (process)
            begin
                wr_ptr_reg <= wr_ptr_reg + LS_AW'(1);
            end
        end
    end

    // Line store reads: the four upper window rows and the pass-through pixel.
    assign rd_a_addr[0] = wr_ptr_reg - d_row_reg[0];
    assign rd_a_addr[1] = wr_ptr_reg - d_row_reg[1];
    assign rd_b_addr[0] = wr_ptr_reg - d_row_reg[2];
    assign rd_b_addr[1] = wr_ptr_reg - d_row_reg[3];
    assign rd_c_addr[0] = wr_ptr_reg - LS_AW'(lag_reg);

    gb5_line_store #(
        .AW  (LS_AW),
        .DW  (gb5_pkg::PIX_W),
        .NRD (2)
    ) u_store_a (
        .clk     (clk),
        .wr_en   (process),
        .wr_addr (wr_ptr_reg),
        .wr_data (px),
        .rd_addr (rd_a_addr),
        .rd_data (rd_a_data)
    );

    gb5_line_store #(
        .AW  (LS_AW),
        .DW  (gb5_pkg::PIX_W),
        .NRD (2)
    ) u_store_b (
        .clk     (clk),
        .wr_en   (process),
        .wr_addr (wr_ptr_reg),
        .wr_data (px),
        .rd_addr (rd_b_addr),
        .rd_data (rd_b_data)
    );

    gb5_line_store #(
        .AW  (LS_AW),
        .DW  (gb5_pkg::PIX_W),
        .NRD (1)
    ) u_store_c (
        .clk     (clk),
        .wr_en   (process),
        .wr_addr (wr_ptr_reg),
        .wr_data (px),
        .rd_addr (rd_c_addr),
        .rd_data (rd_c_data)
    );

    // Stage 1: decoded item alongside the line store read data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            s1_emit_reg     <= 1'b0;
            s1_interior_reg <= 1'b0;
            s1_last_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg    <= process;
            s1_emit_reg     <= emit;
            s1_interior_reg <= interior;
            s1_last_reg     <= last;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_px_reg <= px;
    end

    // New window column: four rows from the line store, the bottom row from the item itself.
    always_comb
    begin
        col_pix[0] = gb5_pkg::pixel_t'(rd_a_data[0]);
        col_pix[1] = gb5_pkg::pixel_t'(rd_a_data[1]);
        col_pix[2] = gb5_pkg::pixel_t'(rd_b_data[0]);
        col_pix[3] = gb5_pkg::pixel_t'(rd_b_data[1]);
        col_pix[4] = s1_px_reg;
        for (int ch = 0; ch < gb5_pkg::NUM_CHAN; ch++)
        begin
            for (int k = 0; k < gb5_pkg::WIN; k++)
            begin
                lane_col[ch][k] = col_pix[k][ch];
            end
        end
    end

    // One lane per color channel.
    for (genvar ch = 0; ch < gb5_pkg::NUM_CHAN; ch++)
    begin : g_lane
        gb5_lane u_lane (
            .clk      (clk),
            .shift_en (s1_valid_reg),
            .col_in   (lane_col[ch]),
            .quot     (lane_quot[ch])
        );
    end

    // Result flags travel alongside the lanes to the merge stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_info_reg <= '0;
            for (int i = 0; i < gb5_pkg::LANE_LAT; i++)
            begin
                info_pipe_reg[i] <= '0;
            end
        end
        else
        begin
            s2_info_reg.valid    <= s1_valid_reg && s1_emit_reg;
            s2_info_reg.interior <= s1_interior_reg;
            s2_info_reg.last     <= s1_last_reg;
            s2_info_reg.pass     <= gb5_pkg::pixel_t'(rd_c_data[0]);
            info_pipe_reg[0]     <= s2_info_reg;
            for (int i = 1; i < gb5_pkg::LANE_LAT; i++)
            begin
                info_pipe_reg[i] <= info_pipe_reg[i-1];
            end
        end
    end

    gb5_merge u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .info    (info_pipe_reg[gb5_pkg::LANE_LAT-1]),
        .quot    (lane_quot),
        .pix_out (pix_out)
    );

    // The reservation count never exceeds the queue depth.
    a_rsv_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsv_reg <= gb5_pkg::Q_CNT_W'(gb5_pkg::QDEPTH))
        else $error("reservation count above queue depth");

    // Every output transaction was reserved when its item was accepted.
    a_rsv_take: assert property (@(posedge clk) disable iff (!rst_n)
        out_take |-> rsv_reg != '0)
        else $error("output transaction without reservation");

    // A configuration write keeps input off while the geometry settles.
    a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> !pix_in.ready)
        else $error("input accepted right after a configuration write");

    // A frame end marker only comes with an item that gives a result.
    a_last_emit: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_last_reg |-> s1_emit_reg)
        else $error("frame end on an item without a result");

endmodule
